FILE: design/mtp_pkg.sv
package mtp_pkg;

   localparam int STATE_WORDS   = 624;
   localparam int MIDDLE_OFFSET = 397;
   localparam int IDX_W         = 10;

   localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
   localparam logic [31:0] INIT_MULT    = 32'd1812433253;
   localparam logic [31:0] UPPER_BIT    = 32'h8000_0000;
   localparam logic [31:0] LOWER_BITS   = 32'h7fff_ffff;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
   localparam logic [IDX_W:0]   MID_OFS  = (IDX_W + 1)'(MIDDLE_OFFSET);
   localparam logic [IDX_W:0]   WRAP_LEN = (IDX_W + 1)'(STATE_WORDS);

   typedef struct packed {
      logic        func;
      logic [31:0] seed_value;
   } req_type;

   typedef struct packed {
      logic [31:0] random_word;
      logic        ok;
   } rsp_type;

   typedef struct packed {
      logic load_seed;
      logic seed_first;
      logic seed_mul;
      logic seed_add;
      logic seed_done;
      logic gen_finish;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
   } dp_status_type;

   function automatic logic [31:0] temper(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic [31:0] twist(input logic [31:0] cur, input logic [31:0] nxt,
                                         input logic [31:0] mid);
      logic [31:0] x;
      logic [31:0] xa;
      x  = (cur & UPPER_BIT) | (nxt & LOWER_BITS);
      xa = (x >> 1) ^ (x[0] ? TWIST_MATRIX : 32'd0);
      return mid ^ xa;
   endfunction

endpackage

FILE: design/mtp_ctrl.sv
module mtp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_func,
   input  mtp_pkg::dp_status_type status,
   output mtp_pkg::dp_cmd_type    cmd,
   output logic                  busy
);
   import mtp_pkg::*;

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_GEN        = 3'd1;
   localparam logic [2:0] ST_SEED_FIRST = 3'd2;
   localparam logic [2:0] ST_SEED_MUL   = 3'd3;
   localparam logic [2:0] ST_SEED_ADD   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func) begin
                  cmd.load_seed = 1'b1;
                  state_in      = ST_SEED_FIRST;
               end else begin
                  state_in = ST_GEN;
               end
            end
         end
         ST_GEN: begin
            cmd.gen_finish = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SEED_FIRST: begin
            cmd.seed_first = 1'b1;
            state_in       = ST_SEED_MUL;
         end
         ST_SEED_MUL: begin
            cmd.seed_mul = 1'b1;
            state_in     = ST_SEED_ADD;
         end
         ST_SEED_ADD: begin
            cmd.seed_add = 1'b1;
            if (status.fill_last) begin
               cmd.seed_done = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_SEED_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/mtp_dpath.sv
module mtp_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            seed_value,
   input  mtp_pkg::dp_cmd_type    cmd,
   output mtp_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output mtp_pkg::rsp_type       rsp_data
);
   import mtp_pkg::*;

   logic [31:0] mem [STATE_WORDS];

   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             seeded_ff, seeded_in;
   logic [IDX_W-1:0] fill_idx_ff, fill_idx_in;
   logic [31:0]      v_ff, v_in;
   logic [31:0]      prod_ff, prod_in;
   logic [31:0]      cur_word_ff, cur_word_in;
   logic [31:0]      rd_nb_ff, rd_mid_ff;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [IDX_W-1:0] nb_idx;
   logic [IDX_W-1:0] mid_idx;
   logic [IDX_W:0]   mid_sum;
   logic [31:0]      new_word;
   logic [31:0]      seed_sum;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;

   assign nb_idx   = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
   assign mid_sum  = {1'b0, pos_ff} + MID_OFS;
   assign mid_idx  = (mid_sum >= WRAP_LEN) ? IDX_W'(mid_sum - WRAP_LEN) : mid_sum[IDX_W-1:0];
   assign new_word = twist(cur_word_ff, rd_nb_ff, rd_mid_ff);
   assign seed_sum = prod_ff + {{(32 - IDX_W){1'b0}}, fill_idx_ff};
   assign prod_in  = INIT_MULT * (v_ff ^ (v_ff >> 30));

   assign status.fill_last = (fill_idx_ff == LAST_IDX);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = new_word;
      if (cmd.seed_first) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = v_ff;
      end else if (cmd.seed_add) begin
         wr_en   = 1'b1;
         wr_addr = fill_idx_ff;
         wr_data = seed_sum;
      end else if (cmd.gen_finish && seeded_ff) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      seeded_in   = seeded_ff;
      fill_idx_in = fill_idx_ff;
      v_in        = v_ff;
      cur_word_in = cur_word_ff;
      rsp_in      = rsp_ff;
      if (cmd.load_seed) begin
         v_in        = seed_value;
         cur_word_in = seed_value;
         fill_idx_in = '0;
      end
      if (cmd.seed_mul) begin
         fill_idx_in = fill_idx_ff + 1'b1;
      end
      if (cmd.seed_add) begin
         v_in = seed_sum;
      end
      if (cmd.seed_done) begin
         pos_in    = '0;
         seeded_in = 1'b1;
      end
      if (cmd.gen_finish) begin
         if (seeded_ff) begin
            // word at the new position was just read, keep it for the next beat
            cur_word_in        = rd_nb_ff;
            pos_in             = nb_idx;
            rsp_in.random_word = temper(new_word);
            rsp_in.ok          = 1'b1;
         end else begin
            rsp_in.random_word = '0;
            rsp_in.ok          = 1'b0;
         end
      end
   end

   // reads run every cycle, the position only moves at the end of a beat
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_nb_ff  <= mem[nb_idx];
      rd_mid_ff <= mem[mid_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         seeded_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         seeded_ff     <= seeded_in;
         rsp_strobe_ff <= cmd.gen_finish;
      end
   end

   always_ff @(posedge clock) begin
      fill_idx_ff <= fill_idx_in;
      v_ff        <= v_in;
      prod_ff     <= prod_in;
      cur_word_ff <= cur_word_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: design/mersenne_twister_prng_core.sv
// channel   ports                        direction  beat taken when
// request   start, busy, req_data        in         start && !busy
// response  rsp_strobe, rsp_data         out        rsp_strobe (one cycle)
//
// a generate beat passes through ST_GEN, holding busy while the registered
// reads of the next and middle state words come back; the result is then registered
// a seed beat walks all 624 state words, each after the first through the
// seed multiplier and adder states, and holds busy meanwhile; no result
// synchronous reset clears position, seeded flag, response strobe and controller; the state
// memory is left undefined until the first seed
// responses cannot be held off, each strobe lasts exactly one cycle
module mersenne_twister_prng_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mtp_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output mtp_pkg::rsp_type  rsp_data
);
   import mtp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mtp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   mtp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .seed_value (req_data.seed_value),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: design/mtp_checker.sv
module mtp_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mtp_pkg::req_type req_data,
   input logic             rsp_strobe,
   input mtp_pkg::rsp_type rsp_data
);
   import mtp_pkg::*;

   // a generate beat gives its result once ST_GEN and the response register have passed
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_data.func) |-> ##2 rsp_strobe)
      else $error("generate beat without result");

   // a seed beat holds the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func) |=> (busy && !rsp_strobe))
      else $error("seed beat not taken as busy work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results closer than two cycles");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.ok) |-> (rsp_data.random_word == 32'd0))
      else $error("word not zero on unseeded result");

endmodule

bind mersenne_twister_prng_core mtp_checker u_mtp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

FILE: dv/tb_top.sv
module tb_top;
   import mtp_pkg::*;

   localparam int STALL_LIMIT  = 20000;
   localparam int RANDOM_BEATS = 1300;
   localparam int LONG_RUN     = 700;

   typedef enum logic {
      FUNC_GEN  = 1'b0,
      FUNC_SEED = 1'b1
   } func_type;

   typedef struct {
      func_type    f;
      logic [31:0] s;
      bit          fixed;
      rsp_type     r;
   } step_row_type;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   logic    busy;
   req_type req_data   = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // known answer travelling with the beat, used instead of the prediction
   bit      fixed_use  = 1'b0;
   rsp_type fixed_rsp  = '0;

   logic [31:0]      twist_state [STATE_WORDS];
   logic [IDX_W-1:0] twist_pos  = '0;
   bit               gen_seeded = 1'b0;
   rsp_type          pending_words [$];

   int mismatches   = 0;
   int words_seen   = 0;
   int seeds_taken  = 0;
   int beats_taken  = 0;
   int pos_wraps    = 0;
   int stall_cycles = 0;

   // after two unseeded generates, rows carry the published mt19937 outputs for seed 5489
   step_row_type plan [22] = '{
      '{FUNC_GEN,  32'h0000_0000, 1'b1, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'hffff_ffff, 1'b1, '{32'd0, 1'b0}},
      '{FUNC_SEED, 32'd5489,      1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'haaaa_aaaa, 1'b1, '{32'd3499211612, 1'b1}},
      '{FUNC_GEN,  32'h5555_5555, 1'b1, '{32'd581869302, 1'b1}},
      '{FUNC_GEN,  32'h0000_0000, 1'b1, '{32'd3890346734, 1'b1}},
      '{FUNC_SEED, 32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'hffff_ffff, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_SEED, 32'hffff_ffff, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_SEED, 32'h8000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_SEED, 32'h0000_0001, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_SEED, 32'h0000_0002, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}},
      '{FUNC_GEN,  32'h0000_0000, 1'b0, '{32'd0, 1'b0}}
   };

   mersenne_twister_prng_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void reseed_twister(input logic [31:0] seed);
      logic [31:0] v;
      v = seed;
      twist_state[0] = v;
      for (int i = 1; i < STATE_WORDS; i++) begin
         v = INIT_MULT * (v ^ (v >> 30)) + 32'(i);
         twist_state[i] = v;
      end
      twist_pos  = '0;
      gen_seeded = 1'b1;
   endfunction

   function automatic rsp_type draw_word();
      int unsigned k;
      int unsigned nb;
      int unsigned md;
      logic [31:0] x;
      logic [31:0] y;
      rsp_type     r;
      r = '0;
      if (!gen_seeded) return r;
      k  = 32'(twist_pos);
      nb = (k + 1) % STATE_WORDS;
      md = (k + MIDDLE_OFFSET) % STATE_WORDS;
      x  = {twist_state[k][31], twist_state[nb][30:0]};
      y  = {1'b0, x[31:1]};
      if (x[0]) y = y ^ TWIST_MATRIX;
      x = twist_state[md] ^ y;
      twist_state[k] = x;
      twist_pos = IDX_W'(nb);
      if (nb == 0) pos_wraps++;
      // output tempering
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      r.random_word = y;
      r.ok          = 1'b1;
      return r;
   endfunction

   // results are checked before the beat of the same edge is predicted
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_words.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual word %h ok %b",
                        $time, rsp_data.random_word, rsp_data.ok);
            end else begin
               want = pending_words.pop_front();
               words_seen++;
               if (rsp_data.random_word !== want.random_word) begin
                  mismatches++;
                  $display("%0t: random_word mismatch, expected %h actual %h",
                           $time, want.random_word, rsp_data.random_word);
               end
               if (rsp_data.ok !== want.ok) begin
                  mismatches++;
                  $display("%0t: ok mismatch, expected %b actual %b",
                           $time, want.ok, rsp_data.ok);
               end
            end
         end
         if (start && !busy) begin
            beats_taken++;
            if (req_data.func == FUNC_SEED) begin
               reseed_twister(req_data.seed_value);
               seeds_taken++;
            end else begin
               want = draw_word();
               if (fixed_use) want = fixed_rsp;
               pending_words.push_back(want);
            end
         end
      end
   end

   // a seed keeps the block busy while it fills all the state words
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_beat(input func_type f, input logic [31:0] s, input bit fixed,
                            input rsp_type r);
      req_data.func       <= f;
      req_data.seed_value <= s;
      fixed_use           <= fixed;
      fixed_rsp           <= r;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input bit allow);
      if (allow && $urandom_range(0, 99) < 19) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_words();
      start <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0 || busy);
   endtask

   initial begin
      func_type f;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_beat(plan[i].f, plan[i].s, plan[i].fixed, plan[i].r);
         idle_gap(1'b1);
      end

      // hold off until every word is back before the random part
      drain_words();

      // one seed, then a generate run long enough to wrap the position, then occasional seeds
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i == 0 || (i > LONG_RUN && $urandom_range(0, 79) == 0)) f = FUNC_SEED;
         else f = FUNC_GEN;
         send_beat(f, $urandom(), 1'b0, '0);
         idle_gap(!(i >= 300 && i < 700));
      end

      drain_words();
      repeat (16) @(posedge clock);

      $display("beats taken %0d, of them seeds %0d", beats_taken, seeds_taken);
      $display("words checked %0d, position wraps %0d", words_seen, pos_wraps);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/mtp_pkg.sv
design/mtp_ctrl.sv
design/mtp_dpath.sv
design/mersenne_twister_prng_core.sv
design/mtp_checker.sv
dv/tb_top.sv
